// ===== design/stxlb_pkg.sv =====
package stxlb_pkg;

    localparam int MAX_FRAME   = 64;
    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int TOTAL_W     = $clog2(STORE_DEPTH + 1);
    localparam int MIN_FRAME   = 5;

    localparam logic [7:0] STX_BYTE = 8'h02;
    localparam logic [7:0] ACK_BYTE = 8'h06;
    localparam logic [7:0] ENQ_BYTE = 8'h05;

    localparam logic [6:0] FALLBACK_RESET = 7'd12;

    localparam logic [TOTAL_W-1:0] MIN_TOTAL = TOTAL_W'(MIN_FRAME);
    localparam logic [TOTAL_W-1:0] MAX_TOTAL = TOTAL_W'(MAX_FRAME);
    localparam logic [7:0]         MAX_LEN_LO = 8'(MAX_FRAME - MIN_FRAME);

    localparam int CFG_ADDR_W = 3;
    localparam logic CFG_IDX_FALLBACK = 1'b0;

    typedef enum logic [2:0] {
        KIND_BYTE     = 3'd0,
        KIND_ENQ      = 3'd1,
        KIND_BAD_BCC  = 3'd2,
        KIND_JUNK     = 3'd3,
        KIND_OVERSIZE = 3'd4
    } t_kind;

    typedef enum logic {
        RS_IDLE   = 1'b0,
        RS_REPLAY = 1'b1
    } t_rep_state;

    typedef struct packed {
        logic                res_valid;
        t_kind               kind;
        logic [7:0]          data;
        logic                start;
        logic [TOTAL_W-1:0]  total;
    } t_parse_evt;

endpackage

// ===== design/stxlb_ram.sv =====
module stxlb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/stxlb_parse.sv =====
module stxlb_parse import stxlb_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_rx_byte,
    input  logic [6:0]          i_fallback,
    output t_parse_evt          o_evt,
    output logic                o_we,
    output logic [ADDR_W-1:0]   o_waddr,
    output logic [7:0]          o_wdata
);

    logic [ADDR_W-1:0]  r_pos;
    logic [ADDR_W-1:0]  n_pos;
    logic [TOTAL_W-1:0] r_total;
    logic [TOTAL_W-1:0] n_total;
    logic [7:0]         r_bcc;
    logic [7:0]         n_bcc;
    logic               r_len_hi_nz;
    logic               n_len_hi_nz;

    logic [TOTAL_W-1:0] pos_next;
    logic [TOTAL_W-1:0] fb_eff;
    logic [TOTAL_W-1:0] len_total;
    logic               len_zero;
    logic               oversize;

    always_comb begin
        pos_next  = TOTAL_W'(r_pos) + TOTAL_W'(1);
        fb_eff    = (i_fallback < MIN_TOTAL) ? MIN_TOTAL : i_fallback;
        len_zero  = !r_len_hi_nz && (i_rx_byte == 8'd0);
        len_total = len_zero ? fb_eff : (TOTAL_W'(i_rx_byte) + MIN_TOTAL);
        oversize  = len_zero ? (fb_eff > MAX_TOTAL)
                             : (r_len_hi_nz || (i_rx_byte > MAX_LEN_LO));

        n_pos       = r_pos;
        n_total     = r_total;
        n_bcc       = r_bcc;
        n_len_hi_nz = r_len_hi_nz;
        o_evt       = '0;
        o_evt.kind  = KIND_BYTE;
        o_we        = 1'b0;
        o_waddr     = r_pos;
        o_wdata     = i_rx_byte;

        if (i_accept) begin
            if (r_pos == ADDR_W'(0)) begin
                if (i_rx_byte == STX_BYTE) begin
                    o_we    = 1'b1;
                    n_bcc   = i_rx_byte;
                    n_total = '0;
                    n_pos   = ADDR_W'(1);
                end else if (i_rx_byte == ACK_BYTE) begin
                    o_evt.res_valid = 1'b1;
                    o_evt.kind      = KIND_ENQ;
                    o_evt.data      = ENQ_BYTE;
                end else begin
                    o_evt.res_valid = 1'b1;
                    o_evt.kind      = KIND_JUNK;
                end
            end else if (r_pos == ADDR_W'(1)) begin
                o_we        = 1'b1;
                n_bcc       = r_bcc ^ i_rx_byte;
                n_len_hi_nz = (i_rx_byte != 8'd0);
                n_pos       = ADDR_W'(2);
            end else if (r_pos == ADDR_W'(2)) begin
                if (oversize) begin
                    o_evt.res_valid = 1'b1;
                    o_evt.kind      = KIND_OVERSIZE;
                    n_pos           = '0;
                    n_total         = '0;
                    n_bcc           = '0;
                end else begin
                    o_we    = 1'b1;
                    n_bcc   = r_bcc ^ i_rx_byte;
                    n_total = len_total;
                    n_pos   = ADDR_W'(3);
                end
            end else begin
                o_we = 1'b1;
                if (pos_next >= r_total) begin
                    if (i_rx_byte == r_bcc) begin
                        o_evt.start = 1'b1;
                        o_evt.total = pos_next;
                    end else begin
                        o_evt.res_valid = 1'b1;
                        o_evt.kind      = KIND_BAD_BCC;
                    end
                    n_pos   = '0;
                    n_total = '0;
                    n_bcc   = '0;
                end else begin
                    n_bcc = r_bcc ^ i_rx_byte;
                    n_pos = pos_next[ADDR_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_total <= '0;
            r_bcc   <= '0;
        end else begin
            r_pos   <= n_pos;
            r_total <= n_total;
            r_bcc   <= n_bcc;
        end
        r_len_hi_nz <= n_len_hi_nz;
    end

endmodule

// ===== design/stxlb_replay.sv =====
module stxlb_replay import stxlb_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_parse_evt          i_evt,
    input  logic                i_stall,
    input  logic [7:0]          i_rdata,
    output logic                o_re,
    output logic [ADDR_W-1:0]   o_raddr,
    output logic                o_ready,
    output logic                o_valid,
    output logic [2:0]          o_kind,
    output logic [7:0]          o_data_byte,
    output logic                o_last
);

    t_rep_state         r_state;
    t_rep_state         n_state;
    logic               r_valid;
    logic               n_valid;
    t_kind              r_kind;
    t_kind              n_kind;
    logic [7:0]         r_data;
    logic [7:0]         n_data;
    logic               r_last;
    logic               n_last;
    logic [TOTAL_W-1:0] r_rd_addr;
    logic [TOTAL_W-1:0] n_rd_addr;
    logic [TOTAL_W-1:0] r_total;
    logic [TOTAL_W-1:0] n_total;
    logic               r_pend;
    logic               n_pend;
    logic               r_pend_last;
    logic               n_pend_last;

    logic can_load;
    logic load;
    logic more;
    logic issue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= RS_IDLE;
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_pend  <= n_pend;
        end
        r_kind      <= n_kind;
        r_data      <= n_data;
        r_last      <= n_last;
        r_rd_addr   <= n_rd_addr;
        r_total     <= n_total;
        r_pend_last <= n_pend_last;
    end

    always_comb begin
        can_load = !r_valid || !i_stall;
        load     = r_pend && can_load;
        more     = r_rd_addr < r_total;
        issue    = (r_state == RS_REPLAY) && more && (!r_pend || load);

        n_state     = r_state;
        n_valid     = r_valid && i_stall;
        n_kind      = r_kind;
        n_data      = r_data;
        n_last      = r_last;
        n_rd_addr   = r_rd_addr;
        n_total     = r_total;
        n_pend      = r_pend;
        n_pend_last = r_pend_last;

        case (r_state)
            RS_IDLE: begin
                if (i_evt.res_valid) begin
                    n_valid = 1'b1;
                    n_kind  = i_evt.kind;
                    n_data  = i_evt.data;
                    n_last  = 1'b1;
                end
                if (i_evt.start) begin
                    n_state   = RS_REPLAY;
                    n_rd_addr = '0;
                    n_total   = i_evt.total;
                end
            end
            RS_REPLAY: begin
                if (load) begin
                    n_valid = 1'b1;
                    n_kind  = KIND_BYTE;
                    n_data  = i_rdata;
                    n_last  = r_pend_last;
                end
                if (issue) begin
                    n_rd_addr   = r_rd_addr + TOTAL_W'(1);
                    n_pend      = 1'b1;
                    n_pend_last = (r_rd_addr + TOTAL_W'(1)) == r_total;
                end else if (load) begin
                    n_pend = 1'b0;
                end
                if (load && !more) begin
                    n_state = RS_IDLE;
                end
            end
            default: begin
                n_state = RS_IDLE;
            end
        endcase
    end

    assign o_re        = issue;
    assign o_raddr     = r_rd_addr[ADDR_W-1:0];
    assign o_ready     = (r_state == RS_IDLE) && can_load;
    assign o_valid     = r_valid;
    assign o_kind      = r_kind;
    assign o_data_byte = r_data;
    assign o_last      = r_last;

    a_pend_in_replay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == RS_REPLAY))
        else $error("Read pending outside of a replay.");

    a_addr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == RS_REPLAY) |-> (r_rd_addr <= r_total && r_total <= MAX_TOTAL))
        else $error("Replay address out of the frame.");

    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == RS_IDLE && $past(r_state == RS_REPLAY) && $past(i_rst_n))
        |-> (r_valid && r_last && r_kind == KIND_BYTE))
        else $error("Replay ended without a final frame byte.");

    a_evt_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_evt.start |-> !i_evt.res_valid)
        else $error("Replay start together with a single result.");

endmodule

// ===== design/stx_length_bcc_frame_receiver_top.sv =====
// Frame receiver for STX, 16-bit length, data, ETX and BCC on a serial link.
// The input channel takes one received byte per item on i_rx_byte, and each
// item is accepted when i_valid is high and o_stall is low. The output
// channel gives result items on o_kind, o_data_byte and o_last, and each is
// taken when o_valid is high and i_stall is low.
// A byte that causes a single result (enquiry, junk, oversize or bad BCC)
// shows it in the output register in the cycle after it is accepted.
// Bytes inside a frame are written to the frame memory and give no result.
// When the BCC byte matches, the frame of N bytes is replayed from memory:
// the replay state is registered, each byte goes through the memory read
// register into the output register, one byte per cycle while the
// receiver does not stall, and the input stays stalled until the replay ends.
// Input bytes are taken at one per cycle otherwise, and o_stall stays high
// during a replay and while a result waits in a stalled output register.
// A stall from the receiver holds the output register and the replay read.
// Reset returns the block to hunting for STX with an empty output register,
// and sets fallback_length, at address 0 of the APB port, to 12.
// The frame memory needs no clearing after reset.
module stx_length_bcc_frame_receiver_top import stxlb_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [7:0]            i_rx_byte,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [2:0]            o_kind,
    output logic [7:0]            o_data_byte,
    output logic                  o_last,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic [6:0]        r_fallback;
    logic              ready;
    logic              accept;
    t_parse_evt        evt;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic [7:0]        rdata;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == CFG_IDX_FALLBACK) ? {25'd0, r_fallback} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fallback <= FALLBACK_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == CFG_IDX_FALLBACK) begin
            r_fallback <= pwdata[6:0];
        end
    end

    assign accept  = i_valid && ready;
    assign o_stall = !ready;

    stxlb_parse u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_rx_byte  (i_rx_byte),
        .i_fallback (r_fallback),
        .o_evt      (evt),
        .o_we       (we),
        .o_waddr    (waddr),
        .o_wdata    (wdata)
    );

    stxlb_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    stxlb_replay u_replay (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt       (evt),
        .i_stall     (i_stall),
        .i_rdata     (rdata),
        .o_re        (re),
        .o_raddr     (raddr),
        .o_ready     (ready),
        .o_valid     (o_valid),
        .o_kind      (o_kind),
        .o_data_byte (o_data_byte),
        .o_last      (o_last)
    );

endmodule
